[sv/weighted_manhattan_heuristic_macros.svh]
// Assertion macros shared by the weighted Manhattan heuristic RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WEIGHTED_MANHATTAN_HEURISTIC_MACROS_SVH
`define WEIGHTED_MANHATTAN_HEURISTIC_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WMH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wmh_pkg.sv]
// Shared types, codes and constants of the weighted Manhattan heuristic.
// Depends on nothing; used by every module of the block.
package wmh_pkg;

  // Fixed field widths.
  localparam int TILE_W  = 4;
  localparam int GOAL_W  = 4;
  localparam int MODE_W  = 3;
  localparam int WSUM_W  = 24;
  localparam int DSUM_W  = 7;
  localparam int BLANK_W = 4;

  // Cost values reach (CELL_COUNT-1)*10000 at most, below 2^20.
  localparam int COST_W = 20;
  localparam int unsigned SCALE = 10000;

  // Defaults of the top-level parameters.
  localparam int DEFAULT_BOARD_WIDTH = 4;
  localparam int DEFAULT_CELL_COUNT  = 16;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Operation codes of an input beat.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CELL = 1'b1;

  // Cost mode codes; the two unused codes behave as unit cost.
  localparam logic [MODE_W-1:0] MODE_UNIT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEAVY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SQRT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INVERSE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REVINV  = 3'd5;

  // floor(sqrt(t) * 10000) for each tile number.
  localparam int unsigned SQRT_COST [16] = '{
    0, 10000, 14142, 17320, 20000, 22360, 24494, 26457,
    28284, 30000, 31622, 33166, 34641, 36055, 37416, 38729
  };

  // Class of an item as the front sorts it.
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_CELL = 2'd1,
    KIND_LAST = 2'd2
  } kind_t;

  // One queued item.
  typedef struct packed {
    kind_t             kind;
    logic [TILE_W-1:0] tile;
    logic [GOAL_W-1:0] goal_cell;
  } item_t;

endpackage

[sv/weighted_manhattan_heuristic.sv]
// Weighted Manhattan heuristic: one item per cycle while nothing stalls, board cells and goal loads.
// The result beat is registered once the final cell has passed the front, queue, lookup and product stages.
// Sustained throughput is 1 item per cycle while no finished result is held by out_stall.
// Synchronous active-high reset clears counters, sums, queue and cost mode to unit.
// The goal table is not cleared by reset; every entry must be loaded before use, which the block does not enforce.
// Depends on wmh_pkg, wmh_front, wmh_queue and wmh_back.
module weighted_manhattan_heuristic #(
  parameter int BOARD_WIDTH = wmh_pkg::DEFAULT_BOARD_WIDTH,
  parameter int CELL_COUNT  = wmh_pkg::DEFAULT_CELL_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wmh_pkg::MODE_W-1:0]  cost_mode,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [wmh_pkg::TILE_W-1:0]  tile,
  input  logic [wmh_pkg::GOAL_W-1:0]  goal_cell,
  input  logic                        last,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wmh_pkg::WSUM_W-1:0]  weighted_cost,
  output logic [wmh_pkg::DSUM_W-1:0]  plain_distance,
  output logic [wmh_pkg::BLANK_W-1:0] blank_cell
);

  logic [wmh_pkg::MODE_W-1:0] mode_reg;
  logic                       push_valid;
  logic                       push_full;
  wmh_pkg::item_t             push_item;
  logic                       pop_valid;
  logic                       pop_ready;
  wmh_pkg::item_t             pop_item;

  // Cost mode register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= wmh_pkg::MODE_UNIT;
    end else if (cfg_valid && cfg_ready) begin
      mode_reg <= cost_mode;
    end
  end

  wmh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .tile       (tile),
    .goal_cell  (goal_cell),
    .last       (last),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_item  (push_item)
  );

  wmh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .full       (push_full),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  wmh_back #(
    .BOARD_WIDTH (BOARD_WIDTH),
    .CELL_COUNT  (CELL_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cost_mode      (mode_reg),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .weighted_cost  (weighted_cost),
    .plain_distance (plain_distance),
    .blank_cell     (blank_cell)
  );

endmodule

[sv/wmh_front.sv]
// Front stage: takes input beats, sorts them into goal loads and board cells.
// Depends on wmh_pkg; feeds wmh_queue.
module wmh_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [wmh_pkg::TILE_W-1:0] tile,
  input  logic [wmh_pkg::GOAL_W-1:0] goal_cell,
  input  logic                   last,
  output logic                   push_valid,
  input  logic                   push_full,
  output wmh_pkg::item_t         push_item
);

  logic           front_valid;
  wmh_pkg::item_t item_reg;
  wmh_pkg::kind_t kind;
  logic           accept;

  // Hold the input only while a captured item cannot move on.
  assign in_stall = front_valid && push_full;
  assign accept   = in_valid && !in_stall;

  // Sort the beat; the last flag counts only on a board cell.
  always_comb begin
    case (op)
      wmh_pkg::OP_LOAD: kind = wmh_pkg::KIND_LOAD;
      wmh_pkg::OP_CELL: kind = last ? wmh_pkg::KIND_LAST : wmh_pkg::KIND_CELL;
      default:          kind = wmh_pkg::KIND_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (!push_full) begin
      front_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg.kind      <= kind;
      item_reg.tile      <= tile;
      item_reg.goal_cell <= goal_cell;
    end
  end

  assign push_valid = front_valid;
  assign push_item  = item_reg;

endmodule

[sv/wmh_queue.sv]
// Short queue between the front and the back of the heuristic block.
// Depends on wmh_pkg and the assertion macro header.
`include "weighted_manhattan_heuristic_macros.svh"

module wmh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           full,
  input  wmh_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wmh_pkg::item_t pop_item
);

  localparam int Depth = wmh_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  wmh_pkg::item_t   entries [Depth];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign full      = (count == CNT_W'(Depth));
  assign pop_valid = (count != '0);
  assign push_fire = push_valid && !full;
  assign pop_fire  = pop_valid && pop_ready;
  assign pop_item  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // The head holds until it is taken, and a push into an empty queue shows next cycle.
  `WMH_ASSERT_NEXT(a_head_holds, clk, rst, pop_valid && !pop_ready,
    pop_valid && $stable(pop_item), "queue head changed before it was taken")
  `WMH_ASSERT_NEXT(a_push_shows, clk, rst, push_fire && !pop_valid,
    pop_valid, "pushed beat did not reach the queue head")
  `WMH_ASSERT_NOW(a_count_bound, clk, rst, 1'b1,
    count <= CNT_W'(Depth), "queue fill count above its depth")

endmodule

[sv/wmh_back.sv]
// Back part: goal table, cell counting, distance, cost, the two sums and the blank position.
// Depends on wmh_pkg and the assertion macro header.
`include "weighted_manhattan_heuristic_macros.svh"

module wmh_back #(
  parameter int BOARD_WIDTH = wmh_pkg::DEFAULT_BOARD_WIDTH,
  parameter int CELL_COUNT  = wmh_pkg::DEFAULT_CELL_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [wmh_pkg::MODE_W-1:0]  cost_mode,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  wmh_pkg::item_t              pop_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wmh_pkg::WSUM_W-1:0]  weighted_cost,
  output logic [wmh_pkg::DSUM_W-1:0]  plain_distance,
  output logic [wmh_pkg::BLANK_W-1:0] blank_cell
);

  localparam int TILE_W  = wmh_pkg::TILE_W;
  localparam int TILES   = 1 << TILE_W;
  localparam int COST_W  = wmh_pkg::COST_W;
  localparam int WSUM_W  = wmh_pkg::WSUM_W;
  localparam int DSUM_W  = wmh_pkg::DSUM_W;
  localparam int BLANK_W = wmh_pkg::BLANK_W;
  localparam int CW      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int RCW     = (CW > TILE_W) ? CW : TILE_W;
  localparam int DW      = RCW + 1;
  localparam int PW      = COST_W + DW;
  localparam int WACC_W  = ((PW > WSUM_W) ? PW : WSUM_W) + 1;
  localparam int DACC_W  = ((DW > DSUM_W) ? DW : DSUM_W) + 1;
  localparam int unsigned Scale = wmh_pkg::SCALE;
  localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
  localparam logic [DSUM_W-1:0] DSUM_MAX = {DSUM_W{1'b1}};

  // Constant tables: goal row and column, counted tiles, cost per mode.
  logic [RCW-1:0]    goal_row_lut [TILES];
  logic [RCW-1:0]    goal_col_lut [TILES];
  logic              counted_lut  [TILES];
  logic [COST_W-1:0] cost_lut     [8][TILES];

  for (genvar G = 0; G < TILES; G++) begin : g_goal_lut
    assign goal_row_lut[G] = RCW'(G / BOARD_WIDTH);
    assign goal_col_lut[G] = RCW'(G % BOARD_WIDTH);
    assign counted_lut[G]  = (G > 0) && (G < CELL_COUNT);
  end

  for (genvar M = 0; M < 8; M++) begin : g_cost_mode
    for (genvar T = 0; T < TILES; T++) begin : g_cost_tile
      localparam int unsigned Rev  = (T < CELL_COUNT) ? CELL_COUNT - T : 1;
      localparam int unsigned Tdiv = (T > 0) ? T : 1;
      localparam bit Counted = (T > 0) && (T < CELL_COUNT);
      localparam int unsigned Cost =
        !Counted                      ? 0 :
        (M == wmh_pkg::MODE_HEAVY)    ? T * Scale :
        (M == wmh_pkg::MODE_SQRT)     ? wmh_pkg::SQRT_COST[T] :
        (M == wmh_pkg::MODE_INVERSE)  ? Scale / Tdiv :
        (M == wmh_pkg::MODE_REVERSE)  ? Rev * Scale :
        (M == wmh_pkg::MODE_REVINV)   ? Scale / Rev :
                                        Scale;
      assign cost_lut[M][T] = COST_W'(Cost);
    end
  end

  logic                     advance;
  logic                     pop_fire;
  logic                     is_board;
  logic                     is_last;

  // Goal table and board position.
  logic [TILE_W-1:0]        goal_table [TILES];
  logic [CW-1:0]            cell_idx;
  logic [RCW-1:0]           row;
  logic [RCW-1:0]           col;

  // Lookup results for the item at the queue head.
  logic [TILE_W-1:0]        goal;
  logic [RCW-1:0]           g_row;
  logic [RCW-1:0]           g_col;
  logic [RCW-1:0]           d_row;
  logic [RCW-1:0]           d_col;
  logic [DW-1:0]            tile_dist;
  logic                     counted;

  // Lookup stage registers.
  logic                     s1_valid;
  logic                     s1_last;
  logic                     s1_blank;
  logic [DW-1:0]            s1_dist;
  logic [COST_W-1:0]        s1_cost;
  logic [BLANK_W-1:0]       s1_cell;

  // Product stage registers.
  logic                     s2_valid;
  logic                     s2_last;
  logic                     s2_blank;
  logic [DW-1:0]            s2_dist;
  logic [PW-1:0]            s2_product;
  logic [BLANK_W-1:0]       s2_cell;

  // Accumulators.
  logic [WSUM_W-1:0]        weighted_sum;
  logic [DSUM_W-1:0]        distance_sum;
  logic [BLANK_W-1:0]       blank_reg;
  logic [WACC_W-1:0]        wsum_add;
  logic [DACC_W-1:0]        dsum_add;
  logic [WSUM_W-1:0]        wsum_next;
  logic [DSUM_W-1:0]        dsum_next;
  logic [BLANK_W-1:0]       blank_next;
  logic                     acc_fire;
  logic                     result_fire;

  // The whole back moves unless a finished result is held.
  assign advance   = !out_valid || !out_stall;
  assign pop_ready = advance;
  assign pop_fire  = pop_valid && advance;

  always_comb begin
    is_board = 1'b0;
    is_last  = 1'b0;
    case (pop_item.kind)
      wmh_pkg::KIND_LOAD: begin
        is_board = 1'b0;
      end
      wmh_pkg::KIND_CELL: begin
        is_board = 1'b1;
      end
      wmh_pkg::KIND_LAST: begin
        is_board = 1'b1;
        is_last  = 1'b1;
      end
      default: begin
        is_board = 1'b0;
      end
    endcase
  end

  // Manhattan distance from the current cell to the tile's goal cell.
  always_comb begin
    goal      = goal_table[pop_item.tile];
    g_row     = goal_row_lut[goal];
    g_col     = goal_col_lut[goal];
    d_row     = (row >= g_row) ? row - g_row : g_row - row;
    d_col     = (col >= g_col) ? col - g_col : g_col - col;
    tile_dist = DW'(d_row) + DW'(d_col);
    counted   = counted_lut[pop_item.tile];
  end

  // Goal loads write the table in queue order.
  always_ff @(posedge clk) begin
    if (pop_fire && !is_board) begin
      goal_table[pop_item.tile] <= pop_item.goal_cell;
    end
  end

  // Cell, row and column counters follow the board cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_idx <= '0;
      row      <= '0;
      col      <= '0;
    end else if (pop_fire && is_board) begin
      if (is_last || cell_idx == CW'(CELL_COUNT - 1)) begin
        cell_idx <= '0;
        row      <= '0;
        col      <= '0;
      end else begin
        cell_idx <= cell_idx + 1'b1;
        if (col == RCW'(BOARD_WIDTH - 1)) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  // Lookup and product stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pop_fire && is_board;
      s2_valid <= s1_valid;
    end
  end

  // Lookup and product stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last    <= is_last;
      s1_blank   <= (pop_item.tile == '0);
      s1_dist    <= counted ? tile_dist : '0;
      s1_cost    <= cost_lut[cost_mode][pop_item.tile];
      s1_cell    <= BLANK_W'(cell_idx);
      s2_last    <= s1_last;
      s2_blank   <= s1_blank;
      s2_dist    <= s1_dist;
      s2_product <= PW'(s1_cost) * PW'(s1_dist);
      s2_cell    <= s1_cell;
    end
  end

  // Saturating sums and the blank position.
  always_comb begin
    wsum_add   = WACC_W'(weighted_sum) + WACC_W'(s2_product);
    dsum_add   = DACC_W'(distance_sum) + DACC_W'(s2_dist);
    wsum_next  = (wsum_add > WACC_W'(WSUM_MAX)) ? WSUM_MAX : wsum_add[WSUM_W-1:0];
    dsum_next  = (dsum_add > DACC_W'(DSUM_MAX)) ? DSUM_MAX : dsum_add[DSUM_W-1:0];
    blank_next = s2_blank ? s2_cell : blank_reg;
  end

  assign acc_fire    = s2_valid && advance;
  assign result_fire = acc_fire && s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_sum <= '0;
      distance_sum <= '0;
      blank_reg    <= '0;
    end else if (result_fire) begin
      weighted_sum <= '0;
      distance_sum <= '0;
      blank_reg    <= '0;
    end else if (acc_fire) begin
      weighted_sum <= wsum_next;
      distance_sum <= dsum_next;
      blank_reg    <= blank_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      weighted_cost  <= wsum_next;
      plain_distance <= dsum_next;
      blank_cell     <= blank_next;
    end
  end

  // A final cell produces a result and leaves the sums cleared; a held result freezes them.
  `WMH_ASSERT_NEXT(a_result_shown, clk, rst, result_fire, out_valid,
    "final cell did not produce a result beat")
  `WMH_ASSERT_NEXT(a_sums_cleared, clk, rst, result_fire,
    weighted_sum == '0 && distance_sum == '0 && blank_reg == '0,
    "sums not cleared after a result")
  `WMH_ASSERT_NEXT(a_held_freezes, clk, rst, out_valid && out_stall,
    $stable(weighted_sum) && $stable(distance_sum) && $stable(cell_idx),
    "back moved while a result was held")

endmodule
